FILE: rtl/core/assert_macros.svh
// Assertion macros included by the queue top module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clk edge outside reset
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/csarq_pkg.sv
// Types and codes of the command send / ack / retry queue
package csarq_pkg;

    // Item action codes
    localparam logic [2:0] ACT_UPDATE    = 3'd0;
    localparam logic [2:0] ACT_PUSH_MODE = 3'd1;
    localparam logic [2:0] ACT_PUSH_STEP = 3'd2;
    localparam logic [2:0] ACT_CLEAR     = 3'd3;
    localparam logic [2:0] ACT_TICK      = 3'd4;
    localparam logic [2:0] ACT_REPLY     = 3'd5;

    // Parsed reply kinds
    localparam logic [1:0] RPL_MISSED = 2'd0;
    localparam logic [1:0] RPL_MODE   = 2'd1;
    localparam logic [1:0] RPL_STEP   = 2'd2;

    // Configuration register indexes
    localparam logic CFG_ACK_TIMEOUT = 1'b0;
    localparam logic CFG_SKIP_ACK    = 1'b1;

    localparam logic [15:0] ACK_TIMEOUT_RESET = 16'd100;
    localparam logic [15:0] ELAPSED_MAX       = 16'hFFFF;

    // One queued command: kind bit (0 mode, 1 step), mode and step values
    typedef struct packed {
        logic       is_step;
        logic [1:0] mode;
        logic [7:0] step;
    } cmd_entry_t;

endpackage

FILE: rtl/core/command_send_ack_retry_queue_top.sv
// Command send / acknowledge / retry sender with a ring FIFO of commands
//
// One item is accepted on every clock where start is high; busy is always low.
// The item is registered on entry and processed against the queue, sender FSM,
// ms counter and reply latch in the following cycle. Its result is registered at
// the next clock edge and sits on the result ports with done high for a single
// cycle. Sustained rate is one item per clock; the state update sits between the
// input register and the result register. The queue head is read from the FIFO
// memory through a registered read port with write bypass.
module command_send_ack_retry_queue_top #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    output logic                               done,
    input  logic                               cfg_we,
    input  logic                               cfg_index,
    input  logic [15:0]                        cfg_data,
    input  logic [2:0]                         action,
    input  logic [1:0]                         cmd_mode,
    input  logic [7:0]                         cmd_step,
    input  logic [1:0]                         reply_kind,
    input  logic [1:0]                         reply_mode,
    input  logic [7:0]                         reply_step,
    output logic                               send_valid,
    output logic                               send_kind,
    output logic [1:0]                         send_mode,
    output logic [7:0]                         send_step,
    output logic                               push_dropped,
    output logic                               confirmed,
    output logic [2:0]                         sender_state,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]   queue_count
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_SEND  = 3'd1,
        ST_AWAIT = 3'd2,
        ST_DONE  = 3'd3,
        ST_RETRY = 3'd4
    } state_t;

    // Configuration
    logic [15:0] ack_timeout_reg;
    logic        skip_ack_reg;

    // Input stage
    logic       in_valid_reg;
    logic [2:0] action_reg;
    logic [1:0] cmd_mode_reg;
    logic [7:0] cmd_step_reg;
    logic [1:0] reply_kind_reg;
    logic [1:0] reply_mode_reg;
    logic [7:0] reply_step_reg;

    // Queue
    csarq_pkg::cmd_entry_t queue_mem [QUEUE_DEPTH];
    csarq_pkg::cmd_entry_t head_data_reg;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic                  wr_en;
    csarq_pkg::cmd_entry_t wr_data;

    // Sender
    state_t                fsm_reg, fsm_next, fsm_cur;
    logic                  inflight_valid_reg, inflight_valid_next;
    csarq_pkg::cmd_entry_t inflight_reg, inflight_next;
    logic [15:0]           elapsed_reg, elapsed_next;
    logic                  rlatch_valid_reg, rlatch_valid_next;
    logic [1:0]            rlatch_kind_reg, rlatch_kind_next;
    logic [1:0]            rlatch_mode_reg, rlatch_mode_next;
    logic [7:0]            rlatch_step_reg, rlatch_step_next;
    logic                  reply_match;

    // Result values
    logic       send_valid_next, confirmed_next, dropped_next;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            ack_timeout_reg <= csarq_pkg::ACK_TIMEOUT_RESET;
            skip_ack_reg    <= 1'b0;
        end
        else if (cfg_we) begin
            unique case (cfg_index)
                csarq_pkg::CFG_ACK_TIMEOUT: ack_timeout_reg <= cfg_data;
                csarq_pkg::CFG_SKIP_ACK:    skip_ack_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end
        else begin
            in_valid_reg <= start & ~busy;
        end
    end

    always_ff @(posedge clk) begin
        if (start && !busy) begin
            action_reg     <= action;
            cmd_mode_reg   <= cmd_mode;
            cmd_step_reg   <= cmd_step;
            reply_kind_reg <= reply_kind;
            reply_mode_reg <= reply_mode;
            reply_step_reg <= reply_step;
        end
    end

    assign reply_match = inflight_valid_reg &&
        ((rlatch_kind_reg == csarq_pkg::RPL_MODE && !inflight_reg.is_step &&
          rlatch_mode_reg == inflight_reg.mode) ||
         (rlatch_kind_reg == csarq_pkg::RPL_STEP && inflight_reg.is_step &&
          rlatch_step_reg == inflight_reg.step));

    always_comb begin
        head_next           = head_reg;
        tail_next           = tail_reg;
        fill_next           = fill_reg;
        wr_en               = 1'b0;
        wr_data             = '0;
        fsm_cur             = fsm_reg;
        fsm_next            = fsm_reg;
        inflight_valid_next = inflight_valid_reg;
        inflight_next       = inflight_reg;
        elapsed_next        = elapsed_reg;
        rlatch_valid_next   = rlatch_valid_reg;
        rlatch_kind_next    = rlatch_kind_reg;
        rlatch_mode_next    = rlatch_mode_reg;
        rlatch_step_next    = rlatch_step_reg;
        send_valid_next     = 1'b0;
        confirmed_next      = 1'b0;
        dropped_next        = 1'b0;

        if (in_valid_reg) begin
            case (action_reg)
                csarq_pkg::ACT_UPDATE: begin
                    // Nothing queued and nothing in flight forces idle first
                    if (fill_reg == '0 && !inflight_valid_reg) begin
                        fsm_cur = ST_IDLE;
                    end
                    fsm_next = fsm_cur;
                    unique case (fsm_cur)
                        ST_IDLE: begin
                            if (fill_reg != '0) begin
                                inflight_valid_next = 1'b1;
                                inflight_next       = head_data_reg;
                                head_next = (head_reg == IDX_LAST) ? '0 : head_reg + 1'b1;
                                fill_next = fill_reg - 1'b1;
                                fsm_next  = ST_SEND;
                            end
                        end
                        ST_SEND: begin
                            if (inflight_valid_reg) begin
                                send_valid_next = 1'b1;
                                elapsed_next    = '0;
                                fsm_next        = skip_ack_reg ? ST_DONE : ST_AWAIT;
                            end
                            else begin
                                fsm_next = ST_IDLE;
                            end
                        end
                        ST_AWAIT: begin
                            if (!inflight_valid_reg) begin
                                fsm_next = ST_IDLE;
                            end
                            else if (rlatch_valid_reg) begin
                                rlatch_valid_next = 1'b0;
                                fsm_next = reply_match ? ST_DONE : ST_RETRY;
                            end
                            else if (elapsed_reg > ack_timeout_reg) begin
                                fsm_next = ST_RETRY;
                            end
                        end
                        ST_DONE: begin
                            inflight_valid_next = 1'b0;
                            inflight_next       = '0;
                            confirmed_next      = 1'b1;
                            fsm_next            = ST_IDLE;
                        end
                        ST_RETRY: begin
                            fsm_next = ST_SEND;
                        end
                        default: begin
                            fsm_next = ST_SEND;
                        end
                    endcase
                end
                csarq_pkg::ACT_PUSH_MODE, csarq_pkg::ACT_PUSH_STEP: begin
                    if (fill_reg == CNT_FULL) begin
                        dropped_next = 1'b1;
                    end
                    else begin
                        wr_en = 1'b1;
                        if (action_reg == csarq_pkg::ACT_PUSH_STEP) begin
                            wr_data.is_step = 1'b1;
                            wr_data.step    = cmd_step_reg;
                        end
                        else begin
                            wr_data.mode = cmd_mode_reg;
                        end
                        tail_next = (tail_reg == IDX_LAST) ? '0 : tail_reg + 1'b1;
                        fill_next = fill_reg + 1'b1;
                    end
                end
                csarq_pkg::ACT_CLEAR: begin
                    head_next           = '0;
                    tail_next           = '0;
                    fill_next           = '0;
                    inflight_valid_next = 1'b0;
                    inflight_next       = '0;
                    fsm_next            = ST_IDLE;
                end
                csarq_pkg::ACT_TICK: begin
                    if (elapsed_reg != csarq_pkg::ELAPSED_MAX) begin
                        elapsed_next = elapsed_reg + 16'd1;
                    end
                end
                csarq_pkg::ACT_REPLY: begin
                    rlatch_valid_next = 1'b1;
                    rlatch_kind_next  = reply_kind_reg;
                    rlatch_mode_next  = reply_mode_reg;
                    rlatch_step_next  = reply_step_reg;
                end
                default: ;
            endcase
        end
    end

    // FIFO storage; head entry read registered, with bypass of a write to it
    always_ff @(posedge clk) begin
        if (wr_en) begin
            queue_mem[tail_reg] <= wr_data;
        end
        if (wr_en && tail_reg == head_next) begin
            head_data_reg <= wr_data;
        end
        else begin
            head_data_reg <= queue_mem[head_next];
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            head_reg           <= '0;
            tail_reg           <= '0;
            fill_reg           <= '0;
            fsm_reg            <= ST_IDLE;
            inflight_valid_reg <= 1'b0;
            inflight_reg       <= '0;
            elapsed_reg        <= '0;
            rlatch_valid_reg   <= 1'b0;
            rlatch_kind_reg    <= '0;
            rlatch_mode_reg    <= '0;
            rlatch_step_reg    <= '0;
            done               <= 1'b0;
            send_valid         <= 1'b0;
            send_kind          <= 1'b0;
            send_mode          <= '0;
            send_step          <= '0;
            push_dropped       <= 1'b0;
            confirmed          <= 1'b0;
            sender_state       <= ST_IDLE;
            queue_count        <= '0;
        end
        else begin
            head_reg           <= head_next;
            tail_reg           <= tail_next;
            fill_reg           <= fill_next;
            fsm_reg            <= fsm_next;
            inflight_valid_reg <= inflight_valid_next;
            inflight_reg       <= inflight_next;
            elapsed_reg        <= elapsed_next;
            rlatch_valid_reg   <= rlatch_valid_next;
            rlatch_kind_reg    <= rlatch_kind_next;
            rlatch_mode_reg    <= rlatch_mode_next;
            rlatch_step_reg    <= rlatch_step_next;
            done               <= in_valid_reg;
            send_valid         <= send_valid_next;
            send_kind          <= send_valid_next & inflight_reg.is_step;
            send_mode          <= send_valid_next ? inflight_reg.mode : 2'd0;
            send_step          <= send_valid_next ? inflight_reg.step : 8'd0;
            push_dropped       <= dropped_next;
            confirmed          <= confirmed_next;
            sender_state       <= fsm_next;
            queue_count        <= fill_next;
        end
    end

    `include "assert_macros.svh"

    `ASSERT_IMPLY(a_fill_bound, 1'b1, fill_reg <= CNT_FULL, "queue fill above depth")
    `ASSERT_IMPLY(a_empty_ptrs, fill_reg == '0, head_reg == tail_reg, "empty queue, ptrs differ")
    `ASSERT_IMPLY(a_send_state, done && send_valid, sender_state == ST_AWAIT || sender_state == ST_DONE, "send without await/done")
    `ASSERT_IMPLY(a_conf_idle, done && confirmed, sender_state == ST_IDLE, "confirm not idle")
    `ASSERT_IMPLY(a_drop_full, done && push_dropped, queue_count == CNT_FULL, "drop with room left")
    `ASSERT_NEXT(a_done_follows, in_valid_reg, done, "item result missing")

endmodule
